>>> hdl/fbpa_pkg.sv
// fbpa_pkg: shared constants, types and helpers of the frame buffer pool allocator
// no dependencies; compiled first
package fbpa_pkg;

  // pool geometry
  localparam int unsigned MAX_CACHE_BUFFERS = 7;
  localparam int unsigned ID_BITS           = 16;
  localparam int unsigned POOL_DEPTH        = MAX_CACHE_BUFFERS + 1;
  localparam int unsigned IDX_W             = $clog2(POOL_DEPTH);

  // fixed field widths of the channels
  localparam int unsigned REQ_ID_W = 16;
  localparam int unsigned CFG_W    = 3;
  localparam int unsigned BIDX_W   = 3;
  localparam int unsigned GIDX_W   = 3;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // request kinds
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // id value that marks content as never ready
  localparam id_t ID_NONE = '1;

  // entry usage codes
  typedef enum logic [1:0] {
    USE_FREE    = 2'd0,
    USE_DISPLAY = 2'd1,
    USE_PREPARE = 2'd2
  } use_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic init;    // reinitialise the pool from new cache count
    logic load;    // capture a request word
    logic step;    // examine one entry of the scan
    logic commit;  // update the pool and load the result register
  } fbpa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic put;        // captured request is a put
    logic scan_last;  // scan pointer sits on entry 0
  } fbpa_sts_t;

  // sign-extend the request id, then cut it to the id width
  function automatic id_t to_id(logic signed [REQ_ID_W-1:0] raw);
    logic signed [31:0] ext;
    ext = 32'(raw);
    return ext[ID_BITS-1:0];
  endfunction

  // highest pool entry for a cache count, clamped to the pool size
  function automatic idx_t clamp_top(logic [CFG_W-1:0] v);
    if (32'(v) > MAX_CACHE_BUFFERS) begin
      return IDX_W'(MAX_CACHE_BUFFERS);
    end
    return IDX_W'(v);
  endfunction

endpackage

>>> hdl/fbpa_if.sv
// fbpa_if: valid/ready channel interfaces of the frame buffer pool allocator
// depends on fbpa_pkg
interface fbpa_cfg_if;
  import fbpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] cache_buffers;

  modport source (output valid, output cache_buffers, input ready);
  modport sink   (input valid, input cache_buffers, output ready);
endinterface

interface fbpa_req_if;
  import fbpa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [REQ_ID_W-1:0] request_id;
  logic                       for_display;
  logic [BIDX_W-1:0]          buffer_index;
  logic                       picture_ready;

  modport source (output valid, output action, output request_id, output for_display,
                  output buffer_index, output picture_ready, input ready);
  modport sink   (input valid, input action, input request_id, input for_display,
                  input buffer_index, input picture_ready, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [GIDX_W-1:0] granted_index;
  logic              is_framebuffer;

  modport source (output valid, output granted, output granted_index,
                  output is_framebuffer, input ready);
  modport sink   (input valid, input granted, input granted_index,
                  input is_framebuffer, output ready);
endinterface

>>> hdl/fbpa_ctrl.sv
// fbpa_ctrl: controller state machine, sequences accept, scan and commit
// depends on fbpa_pkg
module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t cmd_o
);
  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // a configuration word goes first, the request word waits while one is offered
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign req_ready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign rsp_valid_o = rsp_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.init = 1'b1;
        end else if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = !sts_i.put;
        if (sts_i.put || sts_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

>>> hdl/fbpa_dp.sv
// fbpa_dp: pool storage, request registers, scan candidates and result register
// depends on fbpa_pkg
module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::fbpa_cmd_t           cmd_i,
  output fbpa_pkg::fbpa_sts_t           sts_o,
  input  logic [fbpa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          action_i,
  input  logic signed [fbpa_pkg::REQ_ID_W-1:0] request_id_i,
  input  logic                          for_display_i,
  input  logic [fbpa_pkg::BIDX_W-1:0]   buffer_index_i,
  input  logic                          picture_ready_i,
  output logic                          granted_o,
  output logic [fbpa_pkg::GIDX_W-1:0]   granted_index_o,
  output logic                          is_framebuffer_o
);
  import fbpa_pkg::*;

  // pool entries
  id_t  id_q  [POOL_DEPTH];
  use_e use_q [POOL_DEPTH];
  logic rdy_q [POOL_DEPTH];

  // captured request
  idx_t              top_q, top_d;
  idx_t              ptr_q;
  logic              act_q;
  id_t               rid_q;
  logic              disp_q;
  logic [BIDX_W-1:0] bidx_q;
  logic              prdy_q;

  // scan candidates: matching id, blank, any free
  logic mf_q, bf_q, ff_q;
  idx_t mi_q, bi_q, fi_q;

  // result register
  logic              granted_q;
  logic [GIDX_W-1:0] gidx_q;
  logic              fb_q;

  // entry under the scan pointer
  id_t  cur_id;
  use_e cur_use;
  logic cur_rdy;
  logic cur_free;

  assign cur_id   = id_q[ptr_q];
  assign cur_use  = use_q[ptr_q];
  assign cur_rdy  = rdy_q[ptr_q];
  assign cur_free = (cur_use == USE_FREE);

  assign top_d = clamp_top(cfg_data_i);

  assign sts_o.put       = (act_q == ACT_PUT);
  assign sts_o.scan_last = (ptr_q == '0);

  // choice of entry for a get
  logic sel_hit, sel_wr_id, sel_clr;
  idx_t sel_idx;
  logic put_ok;

  always_comb begin
    sel_hit   = 1'b1;
    sel_idx   = mi_q;
    sel_wr_id = 1'b0;
    sel_clr   = 1'b0;
    if (mf_q) begin
      sel_idx = mi_q;
    end else if (bf_q) begin
      sel_idx   = bi_q;
      sel_wr_id = 1'b1;
    end else if (ff_q) begin
      sel_idx   = fi_q;
      sel_wr_id = 1'b1;
      sel_clr   = 1'b1;
    end else if (disp_q) begin
      sel_idx   = top_q;
      sel_wr_id = 1'b1;
      sel_clr   = 1'b1;
    end else begin
      sel_hit = 1'b0;
    end
  end

  assign put_ok = (32'(bidx_q) <= 32'(top_q));

  // pool storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        id_q[i]  <= '0;
        use_q[i] <= USE_FREE;
        rdy_q[i] <= 1'b0;
      end
      use_q[0] <= (MAX_CACHE_BUFFERS != 0) ? USE_DISPLAY : USE_FREE;
      top_q    <= IDX_W'(MAX_CACHE_BUFFERS);
    end else if (cmd_i.init) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        id_q[i]  <= '0;
        use_q[i] <= USE_FREE;
        rdy_q[i] <= 1'b0;
      end
      use_q[0] <= (top_d != '0) ? USE_DISPLAY : USE_FREE;
      top_q    <= top_d;
    end else if (cmd_i.commit) begin
      if (act_q == ACT_PUT) begin
        if (put_ok) begin
          use_q[ptr_q] <= USE_FREE;
          rdy_q[ptr_q] <= (cur_rdy || prdy_q) && (cur_id != ID_NONE);
        end
      end else if (sel_hit) begin
        use_q[sel_idx] <= disp_q ? USE_DISPLAY : USE_PREPARE;
        if (sel_wr_id) begin
          id_q[sel_idx] <= rid_q;
        end
        if (sel_clr) begin
          rdy_q[sel_idx] <= 1'b0;
        end
      end
    end
  end

  // request capture and scan, top entry down to entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      act_q  <= ACT_GET;
      rid_q  <= '0;
      disp_q <= 1'b0;
      bidx_q <= '0;
      prdy_q <= 1'b0;
      mf_q   <= 1'b0;
      bf_q   <= 1'b0;
      ff_q   <= 1'b0;
      mi_q   <= '0;
      bi_q   <= '0;
      fi_q   <= '0;
    end else if (cmd_i.load) begin
      act_q  <= action_i;
      rid_q  <= to_id(request_id_i);
      disp_q <= for_display_i;
      bidx_q <= buffer_index_i;
      prdy_q <= picture_ready_i;
      ptr_q  <= (action_i == ACT_PUT) ? IDX_W'(buffer_index_i) : top_q;
      mf_q   <= 1'b0;
      bf_q   <= 1'b0;
      ff_q   <= 1'b0;
    end else if (cmd_i.step) begin
      if (cur_free && (cur_id == rid_q) && !mf_q) begin
        mf_q <= 1'b1;
        mi_q <= ptr_q;
      end
      if (cur_free && !cur_rdy && !bf_q) begin
        bf_q <= 1'b1;
        bi_q <= ptr_q;
      end
      if (cur_free && !ff_q) begin
        ff_q <= 1'b1;
        fi_q <= ptr_q;
      end
      ptr_q <= ptr_q - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (act_q == ACT_PUT) begin
        granted_q <= put_ok;
        gidx_q    <= '0;
        fb_q      <= 1'b0;
      end else begin
        granted_q <= sel_hit;
        gidx_q    <= sel_hit ? GIDX_W'(sel_idx) : '0;
        fb_q      <= sel_hit && (sel_idx == '0);
      end
    end
  end

  assign granted_o        = granted_q;
  assign granted_index_o  = gidx_q;
  assign is_framebuffer_o = fb_q;

endmodule

>>> hdl/frame_buffer_pool_allocator.sv
// frame_buffer_pool_allocator: top level, joins controller and datapath
// depends on fbpa_pkg, fbpa_if, fbpa_ctrl, fbpa_dp
// a get scans entries from the clamped cache count N down to entry 0,
//   a put skips the scan; the scan examines one entry a cycle
// a new word is taken only once the previous result has been committed
// reset: cache count 7, all entries free, blank, id zero, entry 0 held for display
module frame_buffer_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbpa_cfg_if.sink    cfg_i,
  fbpa_req_if.sink    req_i,
  fbpa_rsp_if.source  rsp_o
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  // sequencing
  fbpa_ctrl u_fbpa_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pool and result
  fbpa_dp u_fbpa_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_data_i       (cfg_i.cache_buffers),
    .action_i         (req_i.action),
    .request_id_i     (req_i.request_id),
    .for_display_i    (req_i.for_display),
    .buffer_index_i   (req_i.buffer_index),
    .picture_ready_i  (req_i.picture_ready),
    .granted_o        (rsp_o.granted),
    .granted_index_o  (rsp_o.granted_index),
    .is_framebuffer_o (rsp_o.is_framebuffer)
  );

endmodule

>>> hdl/fbpa_checker.sv
// fbpa_checker: port-level assertions on the frame buffer pool allocator
// depends on fbpa_pkg; bound to frame_buffer_pool_allocator
module fbpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        granted_i,
  input logic [fbpa_pkg::GIDX_W-1:0] granted_index_i,
  input logic                        is_framebuffer_i
);
  import fbpa_pkg::*;

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(granted_i)
      && $stable(granted_index_i) && $stable(is_framebuffer_i))
    else $error("result word changed while stalled");

  // a failed request reports no entry
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !granted_i |-> granted_index_i == '0 && !is_framebuffer_i)
    else $error("failed request reports an entry");

  // framebuffer flag only with a grant of entry 0
  a_fb_entry0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && is_framebuffer_i |-> granted_i && granted_index_i == '0)
    else $error("framebuffer flag without entry 0");

  // no result appears in the cycle right after a request word is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !rsp_valid_i |=> !rsp_valid_i)
    else $error("result appeared too early");

endmodule

bind frame_buffer_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .granted_i        (rsp_o.granted),
  .granted_index_i  (rsp_o.granted_index),
  .is_framebuffer_i (rsp_o.is_framebuffer)
);

>>> dv/frame_buffer_pool_allocator_tb.sv
// frame_buffer_pool_allocator_tb: self-checking bench for the frame buffer pool allocator
// drives get and put words, predicts every grant and compares it field by field
// depends on fbpa_pkg, fbpa_if and frame_buffer_pool_allocator
`timescale 1ns / 1ps

module frame_buffer_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int          PHASE_COUNTS [9] = '{7, 0, 3, 1, 7, 5, 2, 6, 4};

  // one request word
  typedef struct packed {
    logic              action;
    logic [REQ_ID_W-1:0] id;
    logic              disp;
    logic [BIDX_W-1:0] bidx;
    logic              prdy;
  } req_word_t;

  // one grant word
  typedef struct packed {
    logic              granted;
    logic [GIDX_W-1:0] index;
    logic              framebuffer;
  } grant_t;

  typedef enum logic [1:0] {
    ROW_CHECKED,
    ROW_PREDICTED,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                action;
    logic [REQ_ID_W-1:0] id;
    logic                disp;
    logic [BIDX_W-1:0]   bidx;
    logic                prdy;
    logic [CFG_W-1:0]    cache_buffers;
    grant_t              grant;
  } dir_row_t;

  // directed table: first at reset (seven caches), then with no caches at all
  dir_row_t dir_table [28] = '{
    '{ROW_CHECKED,   ACT_GET, 16'h0000, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd7, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'hFFFF, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd6, 1'b0}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd6, 1'b1, 3'd0, '{1'b1, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h8000, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd6, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h7FFF, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd5, 1'b0}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd7, 1'b1, 3'd0, '{1'b1, 3'd0, 1'b0}},
    '{ROW_PREDICTED, ACT_GET, 16'h0000, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h0001, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h0002, 1'b1, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h0003, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h0004, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_CHECKED,   ACT_GET, 16'h0009, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b0, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h0009, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd7, 1'b0}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h0005, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd0, 1'b1}},
    '{ROW_PREDICTED, ACT_PUT, 16'h0000, 1'b0, 3'd3, 1'b1, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h004D, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_PREDICTED, ACT_PUT, 16'h0000, 1'b0, 3'd4, 1'b1, 3'd0, '0},
    '{ROW_PREDICTED, ACT_GET, 16'h0001, 1'b1, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_CONFIG,    ACT_GET, 16'h0000, 1'b0, 3'd0, 1'b0, 3'd0, '0},
    '{ROW_CHECKED,   ACT_GET, 16'h0004, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd0, 1'b1}},
    '{ROW_CHECKED,   ACT_GET, 16'h0004, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b0, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd1, 1'b1, 3'd0, '{1'b0, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd0, 1'b1, 3'd0, '{1'b1, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h0008, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd0, 1'b1}},
    '{ROW_CHECKED,   ACT_PUT, 16'h0000, 1'b0, 3'd7, 1'b0, 3'd0, '{1'b0, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h0008, 1'b0, 3'd0, 1'b0, 3'd0, '{1'b0, 3'd0, 1'b0}},
    '{ROW_CHECKED,   ACT_GET, 16'h0008, 1'b1, 3'd0, 1'b0, 3'd0, '{1'b1, 3'd0, 1'b1}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  fbpa_cfg_if cfg_bus ();
  fbpa_req_if req_bus ();
  fbpa_rsp_if rsp_bus ();

  frame_buffer_pool_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // predicted pool contents
  logic [CFG_W-1:0] cache_count;
  id_t              pool_id    [POOL_DEPTH];
  use_e             pool_use   [POOL_DEPTH];
  logic             pool_ready [POOL_DEPTH];
  id_t              recent_ids [8];

  grant_t      pending_grants [$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 21;
  int unsigned recv_stall_pct = 21;
  int unsigned rsp_hold       = 0;
  bit          hold_req       = 1'b0;
  bit          hold_done      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // highest entry in use for the current cache count
  function automatic idx_t pool_top();
    if (int'(cache_count) > int'(MAX_CACHE_BUFFERS)) begin
      return idx_t'(MAX_CACHE_BUFFERS);
    end
    return idx_t'(cache_count);
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_id[i]    = '0;
      pool_use[i]   = USE_FREE;
      pool_ready[i] = 1'b0;
    end
    if (pool_top() != 0) begin
      pool_use[0] = USE_DISPLAY;
    end
  endfunction

  // grant for one accepted word; updates the predicted pool
  function automatic grant_t predict_grant(input req_word_t w);
    grant_t res;
    idx_t   top;
    id_t    want;
    int     pick;
    int     i;
    res = '0;
    top = pool_top();
    if (w.action == ACT_PUT) begin
      if (w.bidx > top) begin
        return res;
      end
      pool_use[w.bidx] = USE_FREE;
      if (w.prdy) begin
        pool_ready[w.bidx] = 1'b1;
      end
      if (pool_id[w.bidx] == ID_NONE) begin
        pool_ready[w.bidx] = 1'b0;
      end
      res.granted = 1'b1;
      return res;
    end
    want = id_t'(int'($signed(w.id)));
    pick = -1;
    // free entry already holding the id
    for (i = int'(top); i >= 0 && pick < 0; i--) begin
      if (pool_use[i] == USE_FREE && pool_id[i] == want) begin
        pick = i;
      end
    end
    // free blank entry
    if (pick < 0) begin
      for (i = int'(top); i >= 0 && pick < 0; i--) begin
        if (pool_use[i] == USE_FREE && !pool_ready[i]) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        pool_id[pick] = want;
      end
    end
    // any free entry, old content dropped
    if (pick < 0) begin
      for (i = int'(top); i >= 0 && pick < 0; i--) begin
        if (pool_use[i] == USE_FREE) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        pool_id[pick]    = want;
        pool_ready[pick] = 1'b0;
      end
    end
    // display requests steal the top entry
    if (pick < 0 && w.disp) begin
      pick             = int'(top);
      pool_id[pick]    = want;
      pool_ready[pick] = 1'b0;
    end
    if (pick < 0) begin
      return res;
    end
    pool_use[pick]  = w.disp ? USE_DISPLAY : USE_PREPARE;
    res.granted     = 1'b1;
    res.index       = GIDX_W'(pick);
    res.framebuffer = (pick == 0);
    return res;
  endfunction

  // random word: mostly gets of known ids and puts of busy entries
  function automatic req_word_t random_word();
    req_word_t w;
    idx_t      top;
    idx_t      busy [$];
    int        roll;
    top    = pool_top();
    w      = '0;
    w.id   = REQ_ID_W'($urandom);
    w.disp = 1'($urandom);
    w.bidx = BIDX_W'($urandom);
    w.prdy = 1'($urandom);
    for (int i = 0; i <= int'(top); i++) begin
      if (pool_use[i] != USE_FREE) begin
        busy.push_back(idx_t'(i));
      end
    end
    roll = $urandom_range(99);
    if ((busy.size() > 0 && roll < 45) || roll < 8) begin
      w.action = ACT_PUT;
      roll = $urandom_range(99);
      if (roll < 70 && busy.size() > 0) begin
        w.bidx = busy[$urandom_range(busy.size() - 1)];
      end else if (roll < 90) begin
        w.bidx = BIDX_W'($urandom_range(top));
      end
      // otherwise the random index may lie beyond the pool
    end else begin
      w.action = ACT_GET;
      roll = $urandom_range(99);
      if (roll < 60) begin
        w.id = recent_ids[$urandom_range(7)];
      end else if (roll < 70) begin
        w.id = ID_NONE;
      end
      w.disp = ($urandom_range(99) < 30);
    end
    return w;
  endfunction

  function automatic void note_mismatch(input string field, input int unsigned exp_v,
                                        input logic [GIDX_W-1:0] act_v);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
  endfunction

  task automatic wait_drained();
    while (pending_grants.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // send one word, then record its grant once accepted
  task automatic send_word(input req_word_t w, input bit typed, input grant_t typed_grant);
    grant_t g;
    int     gap;
    if ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.action        <= w.action;
    req_bus.request_id    <= w.id;
    req_bus.for_display   <= w.disp;
    req_bus.buffer_index  <= w.bidx;
    req_bus.picture_ready <= w.prdy;
    @(posedge clk_i);
    while (!req_bus.ready) begin
      @(posedge clk_i);
    end
    g = predict_grant(w);
    pending_grants.push_back(typed ? typed_grant : g);
  endtask

  // new cache count, only once the pool is idle
  task automatic write_cache_count(input logic [CFG_W-1:0] value);
    req_bus.valid <= 1'b0;
    wait_drained();
    cfg_bus.valid         <= 1'b1;
    cfg_bus.cache_buffers <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) begin
      @(posedge clk_i);
    end
    cfg_bus.valid <= 1'b0;
    cache_count = value;
    clear_pool();
  endtask

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // grant checker and receiver stalls
  always @(posedge clk_i) begin : grant_check
    grant_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t: grant word with nothing expected, got %0d/%0d/%0d", $time,
                 rsp_bus.granted, rsp_bus.granted_index, rsp_bus.is_framebuffer);
      end else begin
        want = pending_grants.pop_front();
        if (rsp_bus.granted !== want.granted) begin
          note_mismatch("granted", want.granted, rsp_bus.granted);
        end
        if (rsp_bus.granted_index !== want.index) begin
          note_mismatch("granted_index", want.index, rsp_bus.granted_index);
        end
        if (rsp_bus.is_framebuffer !== want.framebuffer) begin
          note_mismatch("is_framebuffer", want.framebuffer, rsp_bus.is_framebuffer);
        end
      end
    end
    // long hold starts once when asked for
    if (hold_req && !hold_done) begin
      rsp_hold  = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rsp_hold > 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_hold = rsp_hold - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    req_word_t w;
    rst_ni                <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.cache_buffers <= '0;
    req_bus.valid         <= 1'b0;
    req_bus.action        <= ACT_GET;
    req_bus.request_id    <= '0;
    req_bus.for_display   <= 1'b0;
    req_bus.buffer_index  <= '0;
    req_bus.picture_ready <= 1'b0;
    cache_count = CFG_W'(7);
    clear_pool();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CONFIG) begin
        write_cache_count(dir_table[r].cache_buffers);
      end else begin
        w = '{dir_table[r].action, dir_table[r].id, dir_table[r].disp,
              dir_table[r].bidx, dir_table[r].prdy};
        send_word(w, dir_table[r].kind == ROW_CHECKED, dir_table[r].grant);
      end
    end

    // random phases, one cache count each
    foreach (PHASE_COUNTS[p]) begin
      write_cache_count(CFG_W'(PHASE_COUNTS[p]));
      for (int k = 0; k < 7; k++) begin
        recent_ids[k] = id_t'($urandom_range(5));
      end
      recent_ids[7]  = id_t'($urandom);
      send_idle_pct  = (p == 5) ? 0 : 21;
      recv_stall_pct = (p == 5) ? 0 : 21;
      // long receiver hold while words keep coming
      if (p == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until every grant is back
        if (p % 2 == 1 && n == PHASE_ITEMS / 2) begin
          req_bus.valid <= 1'b0;
          wait_drained();
        end
        send_word(random_word(), 1'b0, '0);
      end
    end

    req_bus.valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/fbpa_pkg.sv
hdl/fbpa_if.sv
hdl/fbpa_ctrl.sv
hdl/fbpa_dp.sv
hdl/frame_buffer_pool_allocator.sv
hdl/fbpa_checker.sv
dv/frame_buffer_pool_allocator_tb.sv
